// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int CP_W      = 32;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_SYMBOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_OUTPUT = 2'd1;

  localparam logic [BYTE_W-1:0] ERROR_SYMBOL_RST  = 8'd94;
  localparam logic              NARROW_OUTPUT_RST = 1'b1;

  // continuation bytes look like 10xxxxxx
  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            was_error;
    logic            last;
  } res_t;

  typedef struct packed {
    res_t             res0;
    res_t             res1;
    logic [CNT_W-1:0] cnt;
  } dec_t;

  // number of leading ones of a lead byte, counted from 1 up to 8
  function automatic logic [3:0] lead_ones(input logic [BYTE_W-1:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd1;
    run = 1'b1;
    for (int i = 1; i < BYTE_W; i++) begin
      if (run && b[BYTE_W-1-i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic [CP_W-1:0] shape(input logic narrow,
                                            input logic [CP_W-1:0] v);
    return narrow ? {16'd0, v[15:0]} : v;
  endfunction

endpackage

// ===== rtl/utf8d_decode.sv =====
module utf8d_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  input  logic [utf8d_pkg::BYTE_W-1:0] error_symbol,
  input  logic                         narrow,
  output utf8d_pkg::dec_t              dec
);
  import utf8d_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;

  logic [3:0]        lo;
  logic              lead_emit;
  logic [CP_W-1:0]   lead_val;
  logic [CP_W-1:0]   lead_acc;
  logic [PEND_W-1:0] lead_pend;
  logic [CP_W-1:0]   acc_cont;
  logic [BYTE_W-1:0] data_mask;

  always_comb begin
    lo        = lead_ones(byte_in);
    lead_emit = !byte_in[BYTE_W-1] || (lo == 4'd1);
    // ascii and a lone 10xxxxxx lead both give the low 7 bits
    lead_val  = {25'd0, byte_in[6:0]};
    data_mask = 8'hFF >> lo;
    lead_acc  = {24'd0, byte_in & data_mask};
    lead_pend = 3'(lo - 4'd1);
    acc_cont  = {acc_r[CP_W-7:0], byte_in[5:0]};

    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    dec      = '0;

    if (pend_r != '0) begin
      if (byte_in[7:6] == CONT_TAG) begin
        pend_nxt = pend_r - 3'd1;
        acc_nxt  = acc_cont;
        if (pend_r == 3'd1) begin
          dec.cnt             = 2'd1;
          dec.res0.code_point = shape(narrow, acc_cont);
          dec.res0.last       = 1'b1;
        end
      end else begin
        // malformed continuation: error first, then restart as a lead
        dec.res0.code_point = {24'd0, error_symbol};
        dec.res0.was_error  = 1'b1;
        if (lead_emit) begin
          dec.cnt             = 2'd2;
          dec.res1.code_point = shape(narrow, lead_val);
          dec.res1.last       = 1'b1;
          pend_nxt            = '0;
          acc_nxt             = '0;
        end else begin
          dec.cnt       = 2'd1;
          dec.res0.last = 1'b1;
          pend_nxt      = lead_pend;
          acc_nxt       = lead_acc;
        end
      end
    end else if (lead_emit) begin
      dec.cnt             = 2'd1;
      dec.res0.code_point = shape(narrow, lead_val);
      dec.res0.last       = 1'b1;
    end else begin
      pend_nxt = lead_pend;
      acc_nxt  = lead_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      acc_r  <= '0;
    end else if (go) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== rtl/utf8d_out_buf.sv =====
module utf8d_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  utf8d_pkg::dec_t dec,
  input  logic            pop,
  output logic            can_load,
  output logic            valid,
  output utf8d_pkg::res_t head
);
  import utf8d_pkg::*;

  res_t             slot0_r, slot0_nxt;
  res_t             slot1_r, slot1_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign valid    = (cnt_r != '0);
  assign head     = slot0_r;
  // room for a full pair once the current beat drains
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = dec.cnt;
      slot0_nxt = dec.res0;
      slot1_nxt = dec.res1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== rtl/utf8_stream_decoder_unit.sv =====
// an input byte is registered, then decoded straight into the result buffer
// throughput: one byte per cycle when each byte gives at most one result and
//   out_ready stays high; a byte that gives two results (error then restart)
//   fills the 2-entry result buffer; the next byte waits for its second pop
// reset: synchronous active-low rst_n clears the sequence state, the pipeline
//   valids and sets error_symbol to 94 and narrow_output to 1
module utf8_stream_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [utf8d_pkg::BYTE_W-1:0]    in_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [utf8d_pkg::CP_W-1:0]      out_code_point,
  output logic                            out_was_error,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [utf8d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [utf8d_pkg::BYTE_W-1:0]    cfg_data
);
  import utf8d_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] error_symbol_r;
  logic              narrow_r;

  // input register stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  dec_t dec;
  res_t head;
  logic can_load;
  logic dec_go;
  logic pop;

  // config is always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_symbol_r <= ERROR_SYMBOL_RST;
      narrow_r       <= NARROW_OUTPUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ERROR_SYMBOL:  error_symbol_r <= cfg_data;
        REG_NARROW_OUTPUT: narrow_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a byte leaves the input register when the result buffer can take its pair
  assign pop      = out_valid && out_ready;
  assign dec_go   = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || dec_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  // sequence state plus the per-byte decode
  utf8d_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (dec_go),
    .byte_in      (s1_byte_r),
    .error_symbol (error_symbol_r),
    .narrow       (narrow_r),
    .dec          (dec)
  );

  // result register, up to two beats per byte
  utf8d_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (dec_go),
    .dec      (dec),
    .pop      (pop),
    .can_load (can_load),
    .valid    (out_valid),
    .head     (head)
  );

  assign out_code_point = head.code_point;
  assign out_was_error  = head.was_error;
  assign out_last       = head.last;

`ifndef SYNTH
  // a pair is always an error beat followed by the final beat
  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    dec_go && (dec.cnt == 2'd2) |->
      dec.res0.was_error && !dec.res0.last && dec.res1.last && !dec.res1.was_error)
    else $error("two-result byte not error then last");

  // a single result always closes its byte
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    dec_go && (dec.cnt == 2'd1) |-> dec.res0.last)
    else $error("single result without last");

  // narrow mode keeps decoded values within 16 bits
  a_narrow_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && narrow_r && !out_was_error |-> (out_code_point[31:16] == 16'd0))
    else $error("narrow result exceeds 16 bits");
`endif

endmodule
